/* hdl/lpr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
package lpr_pkg;

	localparam int PAGE_W  = 16;
	localparam int FIDX_W  = 4;
	localparam int CFG_W   = 5;
	localparam int COUNT_W = 32;

	// Reset value of the active frame count register.
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// One page reference.
	typedef struct packed {
		logic              restart;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	// Outcome of one page reference.
	typedef struct packed {
		logic               hit;
		logic [FIDX_W-1:0]  frame_index;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [COUNT_W-1:0] fault_count;
	} rsp_t;

endpackage

/* hdl/lpr_frame_mem.sv */
// Frame storage: page numbers and recency ranks, one shared read port and one write port each.
module lpr_frame_mem #(
	parameter int FRAMES = 16,
	parameter int IW     = 4
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [IW-1:0]             rd_addr,
	output logic [lpr_pkg::PAGE_W-1:0] page_rd_s1,
	output logic [IW-1:0]             rank_rd_s1,
	input  logic                      page_we,
	input  logic [IW-1:0]             page_waddr,
	input  logic [lpr_pkg::PAGE_W-1:0] page_wdata,
	input  logic                      rank_we,
	input  logic [IW-1:0]             rank_waddr,
	input  logic [IW-1:0]             rank_wdata
);
	import lpr_pkg::*;

	logic [PAGE_W-1:0] page_mem [FRAMES];
	logic [IW-1:0]     rank_mem [FRAMES];

	// Registered read of both arrays at the same address.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			page_rd_s1 <= page_mem[rd_addr];
			rank_rd_s1 <= rank_mem[rd_addr];
		end
	end

	// Page write port.
	always_ff @(posedge clk) begin
		if (page_we) begin
			page_mem[page_waddr] <= page_wdata;
		end
	end

	// Rank write port.
	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
	end

endmodule

/* hdl/lru_page_replacement.sv */
// Top level of the LRU page replacement block.
//
// Usage: raise start with a reference word on req while busy is low; the word
// is taken at that clock edge and busy rises on the next cycle. The result
// word appears on rsp, marked by done, which is high for exactly one cycle;
// the receiver cannot stall it and must take it in that cycle.
// Operation: a first pass reads every active frame, up to the clamped active
// frame count, from the frame memory to find a hit, the first empty frame
// and the oldest frame; a second pass reads each rank again and writes back
// its aged value. The single read port of the frame memory sets both passes.
// A new word can be started in the cycle done is high.
// Configuration: cfg_we writes cfg_wdata into the active frame count; write
// it only while busy is low and no result is pending.
// Reset: arst_n clears all valid bits, the fault count and the control state,
// and sets the active frame count to 16. The memories are not cleared; a
// frame without its valid bit reads as empty with rank zero.
module lru_page_replacement #(
	parameter int FRAMES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  lpr_pkg::req_t            req,
	output logic                     done,
	output lpr_pkg::rsp_t            rsp,
	input  logic                     cfg_we,
	input  logic [lpr_pkg::CFG_W-1:0] cfg_wdata
);
	import lpr_pkg::*;

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1) > 0 ? $clog2(FRAMES + 1) : 1;
	localparam logic [IW-1:0] RANK_MAX = IW'(FRAMES - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_WAIT   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_UPD    = 3'd4;
	localparam logic [2:0] ST_UPDW   = 3'd5;

	logic [2:0]          state_q;
	logic [CFG_W-1:0]    cfg_q;
	logic [CW-1:0]       act_q;
	logic [CW-1:0]       act_nx;
	logic [IW-1:0]       ptr_q;
	logic                ptr_last;
	logic [PAGE_W-1:0]   page_q;
	logic [FRAMES-1:0]   valid_q;

	logic                scan_s1;
	logic                upd_s1;
	logic [IW-1:0]       idx_s1;
	logic [PAGE_W-1:0]   page_rd_s1;
	logic [IW-1:0]       rank_rd_s1;
	logic                vld_rd;
	logic [IW-1:0]       rank_eff;

	logic                found_q;
	logic [IW-1:0]       hit_idx_q;
	logic [IW-1:0]       hit_rank_q;
	logic                empty_q;
	logic [IW-1:0]       empty_idx_q;
	logic [IW-1:0]       max_rank_q;
	logic [IW-1:0]       max_idx_q;
	logic [PAGE_W-1:0]   max_page_q;

	logic [IW-1:0]       f_q;
	logic [IW-1:0]       limit_q;
	logic                fill_q;
	logic [COUNT_W-1:0]  fault_q;
	logic [COUNT_W-1:0]  fault_nx;
	rsp_t                rsp_q;
	logic                done_q;

	logic                rd_en;
	logic                page_we;
	logic [IW-1:0]       dec_f;
	logic [IW-1:0]       rank_wdata;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Clamp the configured count to 1..FRAMES.
	always_comb begin
		priority if (cfg_q == '0) begin
			act_nx = CW'(1);
		end else if (32'(cfg_q) > FRAMES) begin
			act_nx = CW'(FRAMES);
		end else begin
			act_nx = CW'(cfg_q);
		end
	end

	assign ptr_last = (CW'(ptr_q) == act_q - CW'(1));
	assign rd_en    = (state_q == ST_SCAN) || (state_q == ST_UPD);
	assign page_we  = (state_q == ST_DECIDE) && !found_q;

	// Frame chosen at the decision step: hit, first empty, or oldest.
	always_comb begin
		priority if (found_q) begin
			dec_f = hit_idx_q;
		end else if (empty_q) begin
			dec_f = empty_idx_q;
		end else begin
			dec_f = max_idx_q;
		end
	end

	// Saturating fault count for a miss.
	assign fault_nx = (fault_q == '1) ? fault_q : fault_q + COUNT_W'(1);

	// Read data seen through the valid bit: an empty frame has rank zero.
	assign vld_rd   = valid_q[idx_s1];
	assign rank_eff = vld_rd ? rank_rd_s1 : '0;

	// Aged rank written back during the update pass.
	always_comb begin
		priority if (idx_s1 == f_q) begin
			rank_wdata = '0;
		end else if (!vld_rd) begin
			rank_wdata = '0;
		end else if ((fill_q || rank_rd_s1 < limit_q) && rank_rd_s1 != RANK_MAX) begin
			rank_wdata = rank_rd_s1 + IW'(1);
		end else begin
			rank_wdata = rank_rd_s1;
		end
	end

	lpr_frame_mem #(
		.FRAMES (FRAMES),
		.IW     (IW)
	) u_mem (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (ptr_q),
		.page_rd_s1 (page_rd_s1),
		.rank_rd_s1 (rank_rd_s1),
		.page_we    (page_we),
		.page_waddr (dec_f),
		.page_wdata (page_q),
		.rank_we    (upd_s1),
		.rank_waddr (idx_s1),
		.rank_wdata (rank_wdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Sequencer, valid bits and fault count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
			act_q   <= CW'(1);
			valid_q <= '0;
			fault_q <= '0;
			done_q  <= 1'b0;
			scan_s1 <= 1'b0;
			upd_s1  <= 1'b0;
		end else begin
			done_q  <= (state_q == ST_UPDW);
			scan_s1 <= (state_q == ST_SCAN);
			upd_s1  <= (state_q == ST_UPD);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						act_q   <= act_nx;
						ptr_q   <= '0;
						state_q <= ST_SCAN;
						if (req.restart) begin
							valid_q <= '0;
							fault_q <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_WAIT;
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				ST_WAIT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					valid_q[dec_f] <= 1'b1;
					if (!found_q) begin
						fault_q <= fault_nx;
					end
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_UPDW;
					end else begin
						ptr_q <= ptr_q + IW'(1);
					end
				end
				ST_UPDW: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search flags gathered during the scan pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (scan_s1) begin
			if (vld_rd && page_rd_s1 == page_q && !found_q) begin
				found_q <= 1'b1;
			end
			if (!vld_rd && !empty_q) begin
				empty_q <= 1'b1;
			end
		end
	end

	// Search payload: request page, read index, hit frame, first empty frame and oldest frame.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			page_q <= req.page_number;
		end
		if (rd_en) begin
			idx_s1 <= ptr_q;
		end
		if (scan_s1) begin
			if (vld_rd && page_rd_s1 == page_q && !found_q) begin
				hit_idx_q  <= idx_s1;
				hit_rank_q <= rank_rd_s1;
			end
			if (!vld_rd && !empty_q) begin
				empty_idx_q <= idx_s1;
			end
			if (idx_s1 == '0 || rank_eff > max_rank_q) begin
				max_rank_q <= rank_eff;
				max_idx_q  <= idx_s1;
				max_page_q <= page_rd_s1;
			end
		end
	end

	// Decision: latch the chosen frame, aging limit and the result word.
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			f_q    <= dec_f;
			fill_q <= !found_q && empty_q;
			limit_q <= found_q ? hit_rank_q : max_rank_q;
			rsp_q.hit           <= found_q;
			rsp_q.frame_index   <= FIDX_W'(dec_f);
			rsp_q.evicted_valid <= !found_q && !empty_q;
			rsp_q.evicted_page  <= (!found_q && !empty_q) ? max_page_q : '0;
			rsp_q.fault_count   <= found_q ? fault_q : fault_nx;
		end
	end

endmodule
